### hdl/bhtp_pkg.sv
// Package for the bucketized hash table probe engine.
// Holds table geometry, derived widths, register indexes and operation codes.
// No dependencies.
`default_nettype none

package bhtp_pkg;

    // Table geometry
    localparam int SEGMENTS = 4;
    localparam int BUCKETS  = 2048;
    localparam int SLOTS    = 4;

    // Field widths
    localparam int KEY_W     = 64;
    localparam int HASH_W    = 64;
    localparam int SEGB_W    = 2;
    localparam int PROBE_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    // Derived widths
    localparam int SEG_W  = $clog2(SEGMENTS);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ROW_W  = SEG_W + BKT_W;
    localparam int ROWS   = SEGMENTS * BUCKETS;
    localparam int ENT_W  = ROW_W + SLOT_W;
    localparam int ENTRIES = ROWS * SLOTS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT  = 1'd1;

    // Register reset values
    localparam logic [SEGB_W-1:0]  SEGB_RESET  = 2'd2;
    localparam logic [PROBE_W-1:0] PROBE_RESET = 12'd50;
    localparam logic [PROBE_W-1:0] PROBE_CAP   = PROBE_W'(BUCKETS);

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // One bucket row of keys
    typedef logic [SLOTS-1:0][KEY_W-1:0] t_key_row;

endpackage

`default_nettype wire

### hdl/bucketized_hash_table_probe.sv
// Bucketized linear-probing hash table engine: insert and search over a
// row-organized key memory and a slot-organized value memory.
// Depends on bhtp_pkg.
//
// Operation: an accepted request probes N buckets, N being 1..min(limit,
//   2048), in state CHECK and then FINISH; a search hit adds a VALRD value
//   memory read between them. A probe limit of zero skips CHECK and fails.
// Throughput: one item at a time, input stalled until its result goes to the
//   output register; one bucket row per cycle from the key memory read port.
// Reset: synchronous, active low. Afterwards the key memory is cleared one row
//   a cycle over every row; input stays stalled until that pass ends.
//   Configuration writes are taken at any time.
`default_nettype none

module bucketized_hash_table_probe (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Configuration write channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [bhtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [bhtp_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // Request channel
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_operation,
    input  wire  [bhtp_pkg::KEY_W-1:0]      i_key,
    input  wire  [bhtp_pkg::KEY_W-1:0]      i_value,
    input  wire  [bhtp_pkg::HASH_W-1:0]     i_key_hash,
    // Result channel
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic                            o_success,
    output logic [bhtp_pkg::KEY_W-1:0]      o_value_out
);
    import bhtp_pkg::*;

    // Controller states
    localparam logic [2:0] ST_CLEAR  = 3'd0;  // post-reset key memory sweep
    localparam logic [2:0] ST_IDLE   = 3'd1;  // waiting for a request
    localparam logic [2:0] ST_CHECK  = 3'd2;  // one bucket row compared per cycle
    localparam logic [2:0] ST_VALRD  = 3'd3;  // value memory read for a search hit
    localparam logic [2:0] ST_FINISH = 3'd4;  // hand result to output register

    // Memories: keys as whole bucket rows, values as single slots
    t_key_row           key_mem [ROWS];
    logic [KEY_W-1:0]   val_mem [ENTRIES];

    // Configuration registers
    logic [SEGB_W-1:0]  r_segment_bits;
    logic [PROBE_W-1:0] r_probe_limit;

    // Control and request context
    logic [2:0]         r_state;
    logic [ROW_W-1:0]   r_clr_addr;
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_val;
    logic [SEG_W-1:0]   r_seg;
    logic [BKT_W-1:0]   r_bucket;
    logic [PROBE_W-1:0] r_remain;
    logic               r_res_success;
    logic [KEY_W-1:0]   r_res_value;
    logic               r_out_valid;
    logic               r_out_success;
    logic [KEY_W-1:0]   r_out_value;

    // Memory read data (registered)
    t_key_row           r_key_rdata;
    logic [KEY_W-1:0]   r_val_rdata;

    // Memory ports
    logic               key_we;
    logic [ROW_W-1:0]   key_waddr;
    t_key_row           key_wdata;
    logic [ROW_W-1:0]   key_raddr;
    logic               val_we;
    logic [ENT_W-1:0]   val_addr;

    // Request decode
    logic               in_accept;
    logic [HASH_W-1:0]  hash_shift;
    logic [SEG_W-1:0]   in_seg;
    logic [BKT_W-1:0]   in_bucket;
    logic [PROBE_W-1:0] in_limit;
    logic [BKT_W-1:0]   next_bucket;

    // Row compare
    logic [SLOTS-1:0]   slot_match;
    logic [SLOT_W-1:0]  hit_slot;
    logic               hit;
    t_key_row           n_row;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_success   = r_out_success;
    assign o_value_out = r_out_value;

    // Segment comes from the top segment_bits of the hash, folded onto the
    // segment count; zero bits always picks segment 0.
    assign hash_shift = i_key_hash >> (7'd64 - {5'd0, r_segment_bits});
    assign in_seg     = (r_segment_bits == '0) ? '0 : hash_shift[SEG_W-1:0];
    assign in_bucket  = i_key_hash[BKT_W-1:0];
    // Probing more buckets than a segment holds cannot change a first match
    assign in_limit   = (r_probe_limit > PROBE_CAP) ? PROBE_CAP : r_probe_limit;
    // Wraps within the segment by natural overflow
    assign next_bucket = r_bucket + 1'b1;

    // Slot compare: insert looks for an empty slot, search for the key
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            if (r_op == OP_SEARCH) begin
                slot_match[s] = (r_key_rdata[s] == r_key);
            end else begin
                slot_match[s] = (r_key_rdata[s] == '0);
            end
        end
    end

    // Lowest matching slot wins
    always_comb begin
        hit_slot = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (slot_match[s]) begin
                hit_slot = SLOT_W'(s);
            end
        end
    end

    assign hit = |slot_match;

    always_comb begin
        n_row           = r_key_rdata;
        n_row[hit_slot] = r_key;
    end

    // Memory port control. The row of the next bucket is read every cycle
    // of the probe so that one bucket is compared per cycle; no row is written
    // until the probe ends, so the speculative read is never stale.
    always_comb begin
        key_we    = 1'b0;
        key_waddr = {r_seg, r_bucket};
        key_wdata = n_row;
        key_raddr = {r_seg, next_bucket};
        val_we    = 1'b0;
        val_addr  = {r_seg, r_bucket, hit_slot};
        case (r_state)
            ST_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr_addr;
                key_wdata = '0;
            end
            ST_IDLE: begin
                key_raddr = {in_seg, in_bucket};
            end
            ST_CHECK: begin
                if (hit && r_op == OP_INSERT) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        r_key_rdata <= key_mem[key_raddr];
    end

    // Value memory: written on an insert hit, read on a search hit
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[val_addr] <= r_val;
        end
        r_val_rdata <= val_mem[val_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_bits <= SEGB_RESET;
            r_probe_limit  <= PROBE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SEGMENT_BITS: r_segment_bits <= i_cfg_data[SEGB_W-1:0];
                CFG_PROBE_LIMIT:  r_probe_limit  <= i_cfg_data[PROBE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request context and result payload (no reset needed)
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= i_operation;
            r_key    <= i_key;
            r_val    <= i_value;
            r_seg    <= in_seg;
            r_bucket <= in_bucket;
            r_remain <= in_limit;
        end else if (r_state == ST_CHECK && !hit) begin
            r_bucket <= next_bucket;
            r_remain <= r_remain - 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                r_res_success <= 1'b0;
                r_res_value   <= '0;
            end
            ST_CHECK: begin
                r_res_success <= hit;
                r_res_value   <= '0;
            end
            ST_VALRD: begin
                r_res_value <= r_val_rdata;
            end
            default: begin
            end
        endcase

        if (r_state == ST_FINISH && (!r_out_valid || !i_out_stall)) begin
            r_out_success <= r_res_success;
            r_out_value   <= r_res_value;
        end
    end

    // Controller and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result loading takes priority over the old one draining
            if (r_state == ST_FINISH && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ROW_W'(ROWS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        // Zero limit examines nothing and fails
                        r_state <= (in_limit == '0) ? ST_FINISH : ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (hit) begin
                        r_state <= (r_op == OP_SEARCH) ? ST_VALRD : ST_FINISH;
                    end else if (r_remain == PROBE_W'(1)) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_VALRD: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
